>>> rtl/ufbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART frame buffer engine package
// Shared opcode codes, register indexes, default depths and the command
// record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ufbe_pkg;

    // Default buffer depths for the top-level parameters.
    localparam int TX_DEPTH_DEF = 16;
    localparam int RX_DEPTH_DEF = 16;

    // Configuration register indexes.
    localparam logic CFG_HEADER_BYTE  = 1'b0;
    localparam logic CFG_FRAME_LENGTH = 1'b1;

    // Command opcodes; the two unused codes are handled as no-ops.
    typedef enum logic [2:0] {
        OP_RX_EVENT   = 3'd0,
        OP_TX_READY   = 3'd1,
        OP_TX_WRITE   = 3'd2,
        OP_TX_START   = 3'd3,
        OP_RX_READ    = 3'd4,
        OP_RX_RELEASE = 3'd5
    } t_opcode;

    // Classified command held in the queue between front and back end.
    typedef struct packed {
        t_opcode    op;
        logic [7:0] data;
        logic [3:0] index;
        logic [4:0] length;
        logic       has_byte;
        logic       err;
        logic       line_idle;
        logic       tx_idx_ok;
        logic       rx_idx_ok;
    } t_cmd;

endpackage

>>> rtl/ufbe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module ufbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read; the read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ufbe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART frame buffer engine front end
// Accepts input transfers, classifies them into commands and queues them
// for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module ufbe_front #(
    parameter int TX_DEPTH = ufbe_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = ufbe_pkg::RX_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [2:0]    i_opcode,
    input  logic [7:0]    i_data,
    input  logic [3:0]    i_index,
    input  logic [4:0]    i_length,
    input  logic          i_has_byte,
    input  logic          i_noise_err,
    input  logic          i_frame_err,
    input  logic          i_overrun_err,
    input  logic          i_line_idle,
    output logic          o_cmd_valid,
    output ufbe_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import ufbe_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    // Classify the incoming item: merge error flags, range-check the index.
    always_comb begin
        w_cmd.op        = t_opcode'(i_opcode);
        w_cmd.data      = i_data;
        w_cmd.index     = i_index;
        w_cmd.length    = i_length;
        w_cmd.has_byte  = i_has_byte;
        w_cmd.err       = i_noise_err | i_frame_err | i_overrun_err;
        w_cmd.line_idle = i_line_idle;
        w_cmd.tx_idx_ok = (32'(i_index) < TX_DEPTH);
        w_cmd.rx_idx_ok = (32'(i_index) < RX_DEPTH);
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Queue payload.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !i_cmd_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && i_cmd_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

>>> rtl/ufbe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART frame buffer engine back end
// Executes one queued command per cycle, unless the output register stalls,
// on the transmit and receive state and buffers, and holds the result there.
// ----------------------------------------------------------------------------
module ufbe_back #(
    parameter int TX_DEPTH = ufbe_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = ufbe_pkg::RX_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  ufbe_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic [7:0]     i_header_byte,
    input  logic [4:0]     i_frame_length,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_tx_valid,
    output logic [7:0]     o_tx_byte,
    output logic           o_tx_busy,
    output logic           o_frame_ready,
    output logic [7:0]     o_read_byte
);
    import ufbe_pkg::*;

    localparam int TAW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RAW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CW  = (TX_DEPTH >= 31) ? 5 : $clog2(TX_DEPTH + 1);

    // Architectural state.
    logic [7:0]    r_tx_pos,  n_tx_pos;
    logic [CW-1:0] r_tx_cnt,  n_tx_cnt;
    logic          r_sending, n_sending;
    logic [4:0]    r_rx_pos,  n_rx_pos;
    logic          r_rcv,     n_rcv;
    logic          r_held,    n_held;

    // Output register.
    logic r_out_valid;
    logic r_tx_valid;
    logic r_tx_busy;
    logic r_frame_ready;
    logic r_rd_sel;

    logic           w_fire;
    logic           w_tx_valid;
    logic           w_rd_sel;
    logic [4:0]     w_lim;
    logic           tx_we, tx_re, rx_we, rx_re;
    logic [TAW-1:0] tx_waddr, tx_raddr;
    logic [RAW-1:0] rx_waddr, rx_raddr;
    logic [7:0]     tx_rdata, rx_rdata;

    assign w_fire    = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_pop = w_fire;

    // Effective frame length, clamped to 1..RX_DEPTH.
    always_comb begin
        if (i_frame_length == 5'd0) begin
            w_lim = 5'd1;
        end else if (32'(i_frame_length) > RX_DEPTH) begin
            w_lim = 5'(RX_DEPTH);
        end else begin
            w_lim = i_frame_length;
        end
    end

    // Command execution.
    always_comb begin
        n_tx_pos   = r_tx_pos;
        n_tx_cnt   = r_tx_cnt;
        n_sending  = r_sending;
        n_rx_pos   = r_rx_pos;
        n_rcv      = r_rcv;
        n_held     = r_held;
        w_tx_valid = 1'b0;
        w_rd_sel   = 1'b0;
        tx_we      = 1'b0;
        tx_re      = 1'b0;
        rx_we      = 1'b0;
        rx_re      = 1'b0;
        tx_waddr   = TAW'(i_cmd.index);
        tx_raddr   = '0;
        rx_waddr   = '0;
        rx_raddr   = RAW'(i_cmd.index);
        if (w_fire) begin
            unique case (i_cmd.op)
                OP_RX_EVENT: begin
                    // Errors restart the store position before the byte.
                    if (i_cmd.err) begin
                        n_rx_pos = 5'd0;
                    end
                    if (i_cmd.has_byte) begin
                        if (r_held) begin
                            n_rcv = 1'b0;
                        end else begin
                            if (!r_rcv) begin
                                n_rcv    = (i_cmd.data == i_header_byte);
                                n_rx_pos = 5'd0;
                            end
                            if (n_rcv) begin
                                // A frame already full restarts at entry zero.
                                if (n_rx_pos >= w_lim) begin
                                    n_rcv    = 1'b0;
                                    n_rx_pos = 5'd0;
                                end
                                rx_we    = 1'b1;
                                rx_waddr = RAW'(n_rx_pos);
                                n_rx_pos = n_rx_pos + 5'd1;
                                if (n_rx_pos >= w_lim) begin
                                    n_rx_pos = 5'd0;
                                    n_held   = 1'b1;
                                    n_rcv    = 1'b0;
                                end
                            end
                        end
                    end
                end
                OP_TX_READY: begin
                    if (r_sending) begin
                        if (r_tx_pos < 8'(r_tx_cnt)) begin
                            w_tx_valid = 1'b1;
                            tx_re      = 1'b1;
                            tx_raddr   = TAW'(r_tx_pos);
                        end else if (i_cmd.line_idle) begin
                            n_sending = 1'b0;
                        end
                        if (r_tx_pos != 8'hFF) begin
                            n_tx_pos = r_tx_pos + 8'd1;
                        end
                    end
                end
                OP_TX_WRITE: begin
                    tx_we = i_cmd.tx_idx_ok;
                end
                OP_TX_START: begin
                    n_tx_cnt   = (32'(i_cmd.length) > TX_DEPTH) ? CW'(TX_DEPTH)
                                                                : CW'(i_cmd.length);
                    n_sending  = 1'b1;
                    n_tx_pos   = 8'd1;
                    w_tx_valid = 1'b1;
                    tx_re      = 1'b1;
                end
                OP_RX_READ: begin
                    rx_re    = i_cmd.rx_idx_ok;
                    w_rd_sel = i_cmd.rx_idx_ok;
                end
                OP_RX_RELEASE: begin
                    n_held = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // State and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_pos      <= 8'd0;
            r_tx_cnt      <= '0;
            r_sending     <= 1'b0;
            r_rx_pos      <= 5'd0;
            r_rcv         <= 1'b0;
            r_held        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_tx_valid    <= 1'b0;
            r_tx_busy     <= 1'b0;
            r_frame_ready <= 1'b0;
            r_rd_sel      <= 1'b0;
        end else begin
            r_tx_pos  <= n_tx_pos;
            r_tx_cnt  <= n_tx_cnt;
            r_sending <= n_sending;
            r_rx_pos  <= n_rx_pos;
            r_rcv     <= n_rcv;
            r_held    <= n_held;
            if (w_fire) begin
                r_out_valid   <= 1'b1;
                r_tx_valid    <= w_tx_valid;
                r_tx_busy     <= n_sending;
                r_frame_ready <= n_held;
                r_rd_sel      <= w_rd_sel;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transmit buffer.
    ufbe_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH),
        .AW    (TAW)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (i_cmd.data),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    // Receive buffer.
    ufbe_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH),
        .AW    (RAW)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (i_cmd.data),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    // Result fields; buffer data shows only where the command read it.
    assign o_out_valid   = r_out_valid;
    assign o_tx_valid    = r_tx_valid;
    assign o_tx_byte     = r_tx_valid ? tx_rdata : 8'd0;
    assign o_tx_busy     = r_tx_busy;
    assign o_frame_ready = r_frame_ready;
    assign o_read_byte   = r_rd_sel ? rx_rdata : 8'd0;

endmodule

>>> rtl/uart_frame_buffer_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART frame buffer engine
// Header-framed receive buffer and indexed transmit buffer driven by
// byte-level UART events, with one result per event.
// ----------------------------------------------------------------------------
// The engine takes one event per clock while the queue has room and returns
// exactly one result per event. An accepted event is written into a two-entry
// command queue and executed by the back end in order when the output register
// is free; the result holds until taken. Sustained throughput is one event per
// cycle without output stalls, set by the single execute stage, which performs
// at most one write and one registered read on each buffer RAM per cycle. Both
// sides stall independently; the queue absorbs output back-pressure. The
// buffers are not cleared by reset, so no start-up sweep is needed; reading an
// entry that was never written returns undefined data. Configuration writes
// take effect at once and are to be made only while the engine is idle.
// ----------------------------------------------------------------------------
module uart_frame_buffer_engine #(
    parameter int TX_DEPTH = ufbe_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = ufbe_pkg::RX_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_data,
    input  logic [3:0] i_index,
    input  logic [4:0] i_length,
    input  logic       i_has_byte,
    input  logic       i_noise_err,
    input  logic       i_frame_err,
    input  logic       i_overrun_err,
    input  logic       i_line_idle,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_tx_busy,
    output logic       o_frame_ready,
    output logic [7:0] o_read_byte
);
    import ufbe_pkg::*;

    logic [7:0] r_header_byte;
    logic [4:0] r_frame_length;
    logic       w_cmd_valid;
    logic       w_cmd_pop;
    t_cmd       w_cmd;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte  <= 8'd0;
            r_frame_length <= 5'd16;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_HEADER_BYTE:  r_header_byte  <= i_cfg_data;
                CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    ufbe_front #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_data        (i_data),
        .i_index       (i_index),
        .i_length      (i_length),
        .i_has_byte    (i_has_byte),
        .i_noise_err   (i_noise_err),
        .i_frame_err   (i_frame_err),
        .i_overrun_err (i_overrun_err),
        .i_line_idle   (i_line_idle),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    ufbe_back #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .i_header_byte  (r_header_byte),
        .i_frame_length (r_frame_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_tx_busy      (o_tx_busy),
        .o_frame_ready  (o_frame_ready),
        .o_read_byte    (o_read_byte)
    );

`ifndef SYNTHESIS
    // An empty command queue always leaves room for a new transfer.
    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cmd_valid |-> o_in_ready)
        else $error("input stalled with an empty command queue");

    // A byte sent on the line means transmission is in progress.
    a_tx_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tx_valid) |-> o_tx_busy)
        else $error("byte sent while transmitter not busy");

    // The queue only hands over a command when the result register can take it.
    a_pop_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !w_cmd_pop)
        else $error("command executed while the result was stalled");

    // A stalled result keeps its transmit byte while the RAM read data holds.
    a_byte_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_tx_byte) && $stable(o_read_byte))
        else $error("result data changed during a stall");
`endif

endmodule

>>> tb/uart_frame_buffer_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART frame buffer engine testbench
// Drives receive, transmit and buffer events through the valid/ready input
// channel. An in-bench model of the engine predicts one result per accepted
// event, and every result transfer is compared field by field in order.
// Bursty sender gaps, receiver stall patterns and several register settings
// are exercised.
// ----------------------------------------------------------------------------
module uart_frame_buffer_engine_test;
    import ufbe_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int DEPTH        = 16;
    localparam int TOTAL_EVENTS = 1650;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 40;

    // Spare opcodes that the engine must treat as no-ops.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Flag bits for building events: {has_byte, noise, frame, overrun, line_idle}.
    localparam logic [4:0] F_NONE    = 5'b00000;
    localparam logic [4:0] F_BYTE    = 5'b10000;
    localparam logic [4:0] F_NOISE   = 5'b01000;
    localparam logic [4:0] F_FRAME   = 5'b00100;
    localparam logic [4:0] F_OVERRUN = 5'b00010;
    localparam logic [4:0] F_IDLE    = 5'b00001;
    localparam logic [4:0] F_ALL     = 5'b11111;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic [3:0] index;
        logic [4:0] length;
        logic       has_byte;
        logic       noise_err;
        logic       frame_err;
        logic       overrun_err;
        logic       line_idle;
    } t_uart_event;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_busy;
        logic       frame_ready;
        logic [7:0] read_byte;
    } t_engine_result;

    typedef enum {SINK_ALWAYS, SINK_COIN, SINK_SLOW, SINK_PERIODIC} t_sink_mode;

    // Block ports.
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_index   = 1'b0;
    logic [7:0] i_cfg_data    = 8'h00;
    logic       i_in_valid    = 1'b0;
    logic       o_in_ready;
    logic [2:0] i_opcode      = 3'd0;
    logic [7:0] i_data        = 8'h00;
    logic [3:0] i_index       = 4'd0;
    logic [4:0] i_length      = 5'd0;
    logic       i_has_byte    = 1'b0;
    logic       i_noise_err   = 1'b0;
    logic       i_frame_err   = 1'b0;
    logic       i_overrun_err = 1'b0;
    logic       i_line_idle   = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready   = 1'b0;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_tx_busy;
    logic       o_frame_ready;
    logic [7:0] o_read_byte;

    // Engine model state.
    logic [7:0] tx_shadow [DEPTH];
    bit         tx_loaded [DEPTH];
    logic [7:0] rx_shadow [DEPTH];
    bit         rx_loaded [DEPTH];
    logic [7:0] tx_pos        = 8'd0;
    logic [4:0] tx_total      = 5'd0;
    bit         sending       = 1'b0;
    logic [4:0] rx_pos        = 5'd0;
    bit         receiving     = 1'b0;
    bit         frame_held    = 1'b0;
    logic [7:0] cfg_header    = 8'h00;
    logic [4:0] cfg_frame_len = 5'd16;

    t_engine_result expected_results [$];

    int          fail_count       = 0;
    int          items_sent       = 0;
    int          results_checked  = 0;
    int          frames_completed = 0;
    int          tx_bytes_sent    = 0;
    int          reg_writes       = 0;
    int          burst_left       = 0;
    int unsigned cycle_count      = 0;
    logic [7:0]  stall_tick       = 8'd0;
    t_sink_mode  stall_mode       = SINK_ALWAYS;

    uart_frame_buffer_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_data        (i_data),
        .i_index       (i_index),
        .i_length      (i_length),
        .i_has_byte    (i_has_byte),
        .i_noise_err   (i_noise_err),
        .i_frame_err   (i_frame_err),
        .i_overrun_err (i_overrun_err),
        .i_line_idle   (i_line_idle),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_tx_busy     (o_tx_busy),
        .o_frame_ready (o_frame_ready),
        .o_read_byte   (o_read_byte)
    );

    // Free-running clock.
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Run guard: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("cycle limit hit with %0d results outstanding",
                     expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Frame length in use, with zero and oversized settings clamped.
    function automatic int rx_frame_limit();
        if (cfg_frame_len == 5'd0) return 1;
        if (cfg_frame_len > DEPTH) return DEPTH;
        return cfg_frame_len;
    endfunction

    // Number of transmit entries loaded contiguously from entry 0.
    function automatic int tx_loaded_prefix();
        int n = 0;
        while (n < DEPTH && tx_loaded[n]) n++;
        return n;
    endfunction

    // Advance the engine model by one event and return the result it gives.
    function automatic t_engine_result predict_engine(t_uart_event ev);
        t_engine_result res;
        int lim;
        bit err;
        res = '0;
        lim = rx_frame_limit();
        err = ev.noise_err | ev.frame_err | ev.overrun_err;
        case (ev.op)
            OP_RX_EVENT: begin
                // Errors rewind the store position before the byte is looked at.
                if (err) rx_pos = 5'd0;
                if (ev.has_byte) begin
                    if (frame_held) begin
                        receiving = 1'b0;
                    end else begin
                        if (!receiving) begin
                            if (ev.data == cfg_header) receiving = 1'b1;
                            rx_pos = 5'd0;
                        end
                        if (receiving) begin
                            // A frame already full restarts at the first entry.
                            if (rx_pos >= lim) begin
                                receiving = 1'b0;
                                rx_pos    = 5'd0;
                            end
                            rx_shadow[rx_pos[3:0]] = ev.data;
                            rx_loaded[rx_pos[3:0]] = 1'b1;
                            rx_pos = rx_pos + 5'd1;
                            if (rx_pos >= lim) begin
                                rx_pos     = 5'd0;
                                frame_held = 1'b1;
                                receiving  = 1'b0;
                                frames_completed++;
                            end
                        end
                    end
                end
            end
            OP_TX_READY: begin
                if (sending) begin
                    if (tx_pos < tx_total) begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = tx_shadow[tx_pos[3:0]];
                    end else if (ev.line_idle) begin
                        sending = 1'b0;
                    end
                    if (tx_pos != 8'd255) tx_pos = tx_pos + 8'd1;
                end
            end
            OP_TX_WRITE: begin
                tx_shadow[ev.index] = ev.data;
                tx_loaded[ev.index] = 1'b1;
            end
            OP_TX_START: begin
                tx_total     = (ev.length > DEPTH) ? 5'(DEPTH) : ev.length;
                sending      = 1'b1;
                tx_pos       = 8'd1;
                res.tx_valid = 1'b1;
                res.tx_byte  = tx_shadow[0];
            end
            OP_RX_READ: begin
                res.read_byte = rx_shadow[ev.index];
            end
            OP_RX_RELEASE: begin
                frame_held = 1'b0;
            end
            default: begin
            end
        endcase
        res.tx_busy     = sending;
        res.frame_ready = frame_held;
        if (res.tx_valid) tx_bytes_sent++;
        return res;
    endfunction

    // Keep buffer reads on entries that hold data: a start needs its entries
    // loaded and a receive read goes to a loaded entry.
    function automatic t_uart_event legalize_event(t_uart_event ev);
        int prefix;
        int pick;
        prefix = tx_loaded_prefix();
        if (ev.op == OP_TX_START) begin
            if (prefix == 0) begin
                ev.op    = OP_TX_WRITE;
                ev.index = 4'd0;
            end else if (prefix < DEPTH && ev.length > prefix) begin
                ev.length = 5'($urandom_range(0, prefix));
            end
        end else if (ev.op == OP_RX_READ && !rx_loaded[ev.index]) begin
            pick  = $urandom_range(0, DEPTH - 1);
            ev.op = OP_SPARE_LO;
            for (int k = 0; k < DEPTH; k++) begin
                if (rx_loaded[(pick + k) % DEPTH]) begin
                    ev.op    = OP_RX_READ;
                    ev.index = 4'(pick + k);
                    break;
                end
            end
        end
        return ev;
    endfunction

    function automatic t_uart_event make_event(logic [2:0] op, logic [7:0] data,
                                               logic [3:0] index, logic [4:0] length,
                                               logic [4:0] flags);
        t_uart_event ev;
        ev.op = op;
        ev.data = data;
        ev.index = index;
        ev.length = length;
        {ev.has_byte, ev.noise_err, ev.frame_err, ev.overrun_err, ev.line_idle} = flags;
        return ev;
    endfunction

    // Event of the given opcode with every other field random.
    function automatic t_uart_event random_event(logic [2:0] op);
        t_uart_event ev;
        ev.op          = op;
        ev.data        = 8'($urandom_range(0, 255));
        ev.index       = 4'($urandom_range(0, 15));
        ev.length      = 5'($urandom_range(0, 31));
        ev.has_byte    = 1'($urandom_range(0, 1));
        ev.noise_err   = ($urandom_range(0, 7) == 0);
        ev.frame_err   = ($urandom_range(0, 7) == 0);
        ev.overrun_err = ($urandom_range(0, 7) == 0);
        ev.line_idle   = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s after %0d results: got %h, expected %h",
                     $time, what, results_checked, got, want);
    endtask

    // Send one event; the sender may idle between bursts of random length.
    task automatic send_event(input t_uart_event ev_in);
        t_uart_event ev;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        ev = legalize_event(ev_in);
        i_opcode      <= ev.op;
        i_data        <= ev.data;
        i_index       <= ev.index;
        i_length      <= ev.length;
        i_has_byte    <= ev.has_byte;
        i_noise_err   <= ev.noise_err;
        i_frame_err   <= ev.frame_err;
        i_overrun_err <= ev.overrun_err;
        i_line_idle   <= ev.line_idle;
        i_in_valid    <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(predict_engine(ev));
        items_sent++;
    endtask

    // Stop sending and wait for every outstanding result, then let the
    // pipeline settle.
    task automatic drain_engine();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        drain_engine();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_HEADER_BYTE) cfg_header = value;
        else cfg_frame_len = value[4:0];
        reg_writes++;
    endtask

    task automatic set_config(input logic [7:0] header, input logic [4:0] frame_len);
        write_register(CFG_HEADER_BYTE, header);
        write_register(CFG_FRAME_LENGTH, {3'b000, frame_len});
    endtask

    // Edge values, every opcode, error flags and the transmit and receive
    // corner cases.
    task automatic test_directed();
        set_config(8'hFF, 5'd0);
        send_event(make_event(OP_TX_WRITE, 8'h00, 4'd0, 5'd0, F_NONE));
        send_event(make_event(OP_TX_WRITE, 8'hFF, 4'd1, 5'd0, F_NONE));
        send_event(make_event(OP_TX_WRITE, 8'h5A, 4'd15, 5'd0, F_NONE));
        // A zero-length start still sends entry 0.
        send_event(make_event(OP_TX_START, 8'h00, 4'd0, 5'd0, F_NONE));
        send_event(make_event(OP_TX_READY, 8'h00, 4'd0, 5'd0, F_NONE));
        send_event(make_event(OP_TX_READY, 8'h00, 4'd0, 5'd0, F_IDLE));
        // Ready while not sending does nothing.
        send_event(make_event(OP_TX_READY, 8'h00, 4'd0, 5'd0, F_IDLE));
        send_event(make_event(OP_TX_START, 8'h00, 4'd0, 5'd2, F_NONE));
        send_event(make_event(OP_TX_READY, 8'h00, 4'd0, 5'd0, F_IDLE));
        send_event(make_event(OP_TX_READY, 8'h00, 4'd0, 5'd0, F_IDLE));
        // Zero frame length acts as one: the header alone fills the frame.
        send_event(make_event(OP_RX_EVENT, 8'h00, 4'd0, 5'd0, F_BYTE));
        send_event(make_event(OP_RX_EVENT, 8'hFF, 4'd0, 5'd0, F_BYTE));
        // A byte while the frame is held is dropped.
        send_event(make_event(OP_RX_EVENT, 8'h12, 4'd0, 5'd0, F_BYTE));
        send_event(make_event(OP_RX_READ, 8'h00, 4'd0, 5'd0, F_NONE));
        send_event(make_event(OP_RX_RELEASE, 8'h00, 4'd0, 5'd0, F_NONE));
        send_event(make_event(OP_RX_EVENT, 8'h00, 4'd0, 5'd0, F_NOISE));
        send_event(make_event(OP_SPARE_LO, 8'hFF, 4'd15, 5'd31, F_ALL));
        send_event(make_event(OP_SPARE_HI, 8'hFF, 4'd15, 5'd31, F_ALL));
        // Oversized frame length clamps to the buffer depth; errors rewind
        // the position without ending reception.
        set_config(8'h00, 5'd31);
        send_event(make_event(OP_RX_EVENT, 8'h00, 4'd0, 5'd0, F_BYTE));
        send_event(make_event(OP_RX_EVENT, 8'h33, 4'd0, 5'd0, F_BYTE | F_FRAME));
        send_event(make_event(OP_RX_EVENT, 8'h44, 4'd0, 5'd0, F_BYTE | F_OVERRUN));
        send_event(make_event(OP_RX_READ, 8'h00, 4'd0, 5'd0, F_NONE));
    endtask

    // Shrink the frame length under a partly filled frame so that the next
    // byte finds the frame already full and restarts at the first entry.
    task automatic test_frame_length_shrink();
        set_config(8'hA5, 5'd8);
        send_event(make_event(OP_RX_EVENT, 8'hA5, 4'd0, 5'd0, F_BYTE));
        repeat (3) send_event(make_event(OP_RX_EVENT, 8'($urandom_range(0, 255)),
                                         4'd0, 5'd0, F_BYTE));
        write_register(CFG_FRAME_LENGTH, 8'd3);
        repeat (3) send_event(make_event(OP_RX_EVENT, 8'($urandom_range(0, 255)),
                                         4'd0, 5'd0, F_BYTE));
        for (int k = 0; k < 4; k++)
            send_event(make_event(OP_RX_READ, 8'h00, 4'(k), 5'd0, F_NONE));
        send_event(make_event(OP_RX_RELEASE, 8'h00, 4'd0, 5'd0, F_NONE));
    endtask

    // Keep the transmitter busy long enough for its position to saturate;
    // a wrapped position would send stale entries again.
    task automatic test_position_saturation();
        send_event(make_event(OP_TX_START, 8'h00, 4'd0, 5'd16, F_NONE));
        repeat (270) send_event(make_event(OP_TX_READY, 8'($urandom_range(0, 255)),
                                           4'd0, 5'd0, F_NONE));
        send_event(make_event(OP_TX_READY, 8'h00, 4'd0, 5'd0, F_IDLE));
    endtask

    // One receive frame with random content and occasional errors or gaps, then,
    // if the frame is held or at random, reads of the buffer and usually a release.
    task automatic rx_frame_sequence();
        t_uart_event ev;
        int lim;
        lim = rx_frame_limit();
        if ($urandom_range(0, 3) == 0) send_event(random_event(OP_RX_EVENT));
        ev = random_event(OP_RX_EVENT);
        {ev.data, ev.has_byte, ev.noise_err, ev.frame_err, ev.overrun_err} =
            {cfg_header, 4'b1000};
        send_event(ev);
        for (int k = 1; k < lim; k++) begin
            ev = random_event(OP_RX_EVENT);
            if ($urandom_range(0, 9) != 0)
                {ev.has_byte, ev.noise_err, ev.frame_err, ev.overrun_err} = 4'b1000;
            send_event(ev);
        end
        if (frame_held || $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) send_event(random_event(OP_RX_READ));
            if ($urandom_range(0, 4) != 0) send_event(random_event(OP_RX_RELEASE));
        end
    endtask

    // Load some transmit entries, start, and feed ready events until done.
    task automatic tx_sequence();
        t_uart_event ev;
        int count;
        int first;
        count = ($urandom_range(0, 4) == 0) ? DEPTH : $urandom_range(1, 6);
        first = $urandom_range(0, 1) ? 0 : $urandom_range(0, DEPTH - 1);
        for (int k = 0; k < count; k++) begin
            ev = random_event(OP_TX_WRITE);
            ev.index = 4'(first + k);
            send_event(ev);
        end
        send_event(random_event(OP_TX_START));
        for (int k = 0; k < 40 && sending; k++) begin
            ev = random_event(OP_TX_READY);
            if (tx_pos >= tx_total) ev.line_idle = ($urandom_range(0, 2) != 0);
            send_event(ev);
        end
    endtask

    // Phases of mixed traffic, each under its own register setting.
    task automatic test_random_traffic(input int item_target);
        int phase_end;
        logic [7:0] header;
        logic [4:0] frame_len;
        while (items_sent < item_target) begin
            case ($urandom_range(0, 3))
                0: header = 8'h00;
                1: header = 8'hFF;
                default: header = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 5))
                0: frame_len = 5'd0;
                1: frame_len = 5'd16;
                2: frame_len = 5'd31;
                3: frame_len = 5'($urandom_range(0, 31));
                default: frame_len = 5'($urandom_range(1, 5));
            endcase
            set_config(header, frame_len);
            phase_end = items_sent + $urandom_range(60, 180);
            if (phase_end > item_target) phase_end = item_target;
            while (items_sent < phase_end) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7: rx_frame_sequence();
                    8, 9, 10, 11, 12, 13: tx_sequence();
                    14, 15: begin
                        repeat ($urandom_range(1, 3)) send_event(random_event(OP_RX_READ));
                        send_event(random_event(OP_RX_RELEASE));
                    end
                    16, 17, 18: begin
                        repeat ($urandom_range(1, 4))
                            send_event(random_event(3'($urandom_range(0, 7))));
                    end
                    default: drain_engine();
                endcase
            end
        end
    endtask

    // Receiver stalls on a pattern that is picked anew each time the stall tick wraps.
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 8'd1;
        if (stall_tick == 8'hFF) stall_mode <= t_sink_mode'($urandom_range(0, 3));
        case (stall_mode)
            SINK_ALWAYS: i_out_ready <= 1'b1;
            SINK_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            SINK_SLOW:   i_out_ready <= ($urandom_range(0, 4) == 0);
            default:     i_out_ready <= (stall_tick[2:0] < 3'd5);
        endcase
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_engine_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", 8'h00, 8'h00);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", 8'(o_tx_valid), 8'(want.tx_valid));
                if (o_tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", o_tx_byte, want.tx_byte);
                if (o_tx_busy !== want.tx_busy)
                    report_mismatch("tx_busy", 8'(o_tx_busy), 8'(want.tx_busy));
                if (o_frame_ready !== want.frame_ready)
                    report_mismatch("frame_ready", 8'(o_frame_ready),
                                    8'(want.frame_ready));
                if (o_read_byte !== want.read_byte)
                    report_mismatch("read_byte", o_read_byte, want.read_byte);
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_frame_length_shrink();
        test_position_saturation();
        test_random_traffic(TOTAL_EVENTS);

        drain_engine();
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding", 8'h00, 8'h00);
        $display("Ran %0d events with %0d results checked:", items_sent, results_checked);
        $display("%0d frames received, %0d bytes sent.", frames_completed, tx_bytes_sent);
        $display("Made %0d register writes across the settings; %0d mismatches seen.",
                 reg_writes, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
